FILE: design/sva_pkg.sv
// Shared types and codes for the voice allocator.
package sva_pkg;

  localparam int unsigned AgeW = 24;
  localparam logic [AgeW-1:0] AgeMax = {AgeW{1'b1}};
  localparam int unsigned MaxRes = 17;

  typedef enum logic [1:0] {
    ST_OFF  = 2'd0,
    ST_PLAY = 2'd1,
    ST_SUS  = 2'd2,
    ST_REL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_KILL    = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    MODE_NOTE_ON  = 3'd0,
    MODE_NOTE_OFF = 3'd1,
    MODE_PEDAL    = 3'd2,
    MODE_REL_ALL  = 3'd3,
    MODE_KILL_ALL = 3'd4,
    MODE_TICK     = 3'd5,
    MODE_FINISHED = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    REG_MIN_KEY   = 3'd0,
    REG_MAX_KEY   = 3'd1,
    REG_POLY_MODE = 3'd2,
    REG_NOTE_ON_EN = 3'd3,
    REG_KEY_LIMIT = 3'd4
  } reg_e;

  typedef struct packed {
    logic [2:0] mode;
    logic [6:0] note;
    logic [6:0] pedal_value;
    logic [3:0] voice;
  } in_t;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] slot;
    logic [6:0] slot_note;
    logic       last;
  } out_t;

  // Per-cycle command broadcast by the sequencer into every cell.
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_SET   = 3'd1,  // set status of the cell at index
    CMD_START = 3'd2,  // play with key, at index
    CMD_KILL  = 3'd3,  // off, age cleared, at index
    CMD_AGE   = 3'd4,  // age every active cell
    CMD_SUS   = 3'd5   // playing cells matching key become sustained
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    status_e    status;
    logic [6:0] key;
  } cell_ctl_t;

  // Values a cell shows to the scan.
  typedef struct packed {
    status_e          status;
    logic [6:0]       key;
    logic [AgeW-1:0]  age;
  } cell_view_t;

endpackage

FILE: design/sva_cell.sv
// One voice cell: status, key and age of a slot; passes its view down the chain.
module sva_cell #(
  parameter int unsigned IdxW = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IdxW-1:0]       my_idx_i,
  input  logic [IdxW-1:0]       sel_idx_i,
  input  sva_pkg::cell_ctl_t    ctl_i,
  input  logic                  load_i,
  input  logic                  shift_i,
  input  sva_pkg::cell_view_t   prev_i,
  output sva_pkg::cell_view_t   view_o,
  output sva_pkg::cell_view_t   pipe_o
);

  sva_pkg::status_e status_q, status_d;
  logic [6:0] key_q, key_d;
  logic [sva_pkg::AgeW-1:0] age_q, age_d;
  sva_pkg::cell_view_t pipe_q;
  logic hit;

  assign hit = (sel_idx_i == my_idx_i);

  always_comb begin
    status_d = status_q;
    key_d = key_q;
    age_d = age_q;
    case (ctl_i.cmd)
      sva_pkg::CMD_SET: if (hit) status_d = ctl_i.status;
      sva_pkg::CMD_START: begin
        if (hit) begin
          status_d = sva_pkg::ST_PLAY;
          key_d = ctl_i.key;
        end
      end
      sva_pkg::CMD_KILL: begin
        if (hit) begin
          status_d = sva_pkg::ST_OFF;
          age_d = '0;
        end
      end
      sva_pkg::CMD_AGE: begin
        if (status_q != sva_pkg::ST_OFF && age_q != sva_pkg::AgeMax) age_d = age_q + 1'b1;
      end
      sva_pkg::CMD_SUS: begin
        if (status_q == sva_pkg::ST_PLAY && key_q == ctl_i.key) status_d = sva_pkg::ST_SUS;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= sva_pkg::ST_OFF;
      age_q <= '0;
    end else begin
      status_q <= status_d;
      age_q <= age_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  // Shift chain: load own view, take the neighbor's, or hold.
  always_ff @(posedge clk_i) begin
    if (load_i) pipe_q <= view_o;
    else if (shift_i) pipe_q <= prev_i;
  end

  assign view_o = '{status: status_q, key: key_q, age: age_q};
  assign pipe_o = pipe_q;

endmodule

FILE: design/synth_voice_allocator_top.sv
// Voice allocator top: sequencer scanning a chain of voice cells.
//
// Channel  Dir  Handshake                 Payload
// in       in   in_valid_i / in_ready_o   in_data_i  (sva_pkg::in_t)
// out      out  out_valid_o / out_ready_i out_data_o (sva_pkg::out_t)
// cfg      in   cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item at a time. A pass loads every cell view into the chain and shifts
// them past the sequencer one slot per cycle, holding while a result cannot be
// taken: load, scan, decide. Items other than note-on take one pass.
// Note-on takes up to two passes (free slot, then mono release or key limit)
// plus start and release steps. Results wait in a pending register for their
// last flag; with it and the output register both full the sequencer holds.
// Reset clears all slots to off; no clearing pass.
module synth_voice_allocator_top #(
  parameter int unsigned VOICES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sva_pkg::in_t       in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sva_pkg::out_t      out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [6:0]         cfg_data_i
);

  localparam int unsigned IdxW = $clog2(VOICES);
  localparam int unsigned CntW = $clog2(VOICES + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(VOICES - 1);
  localparam logic [5:0] DefLimit = 6'(VOICES - 5);
  localparam int unsigned ResW = $clog2(sva_pkg::MaxRes + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_NEXT  = 6'b001000,
    S_FLUSH = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  // Passes within an item.
  typedef enum logic [2:0] {
    P_MAIN  = 3'd0,  // free-slot search, or the item's own scan
    P_MONO  = 3'd1,
    P_START = 3'd2,
    P_LIMIT = 3'd3,
    P_LREL  = 3'd4
  } pass_e;

  state_e state_q, state_d;
  pass_e pass_q, pass_d;

  logic [6:0] min_key_q, max_key_q;
  logic poly_q, non_en_q;
  logic [5:0] limit_q;
  logic pedal_q, kill_pend_q;

  sva_pkg::in_t item_q;
  logic [IdxW-1:0] pos_q;        // scan position
  logic [IdxW-1:0] sel_q;        // cell addressed by a command
  logic found_q;                 // free slot, or note-off match, found
  logic [IdxW-1:0] free_q;
  logic [CntW-1:0] held_q;
  logic [sva_pkg::AgeW-1:0] maxage_q;
  logic old_ok_q;
  logic [IdxW-1:0] old_q;
  logic [ResW-1:0] nres_q;

  sva_pkg::out_t obuf_q;
  logic obuf_v_q;
  logic pend_v_q;
  sva_pkg::out_t pend_q;         // held result awaiting its last flag

  sva_pkg::cell_ctl_t ctl;
  sva_pkg::cell_ctl_t ctl_f;
  logic [IdxW-1:0] ctl_idx;
  logic shift;
  logic load;

  sva_pkg::cell_view_t views [VOICES];
  sva_pkg::cell_view_t pipes [VOICES];
  sva_pkg::cell_view_t cur;

  assign load = (state_q == S_LOAD);

  // Chain: views shift toward cell 0; cur is the slot at pos_q.
  for (genvar g = 0; g < VOICES; g++) begin : g_cell
    sva_pkg::cell_view_t prev;
    if (g == VOICES - 1) begin : g_end
      assign prev = '0;
    end else begin : g_mid
      assign prev = pipes[g+1];
    end
    sva_cell #(.IdxW(IdxW)) u_cell (
      .clk_i, .rst_ni,
      .my_idx_i (IdxW'(g)),
      .sel_idx_i(ctl_idx),
      .ctl_i    (ctl_f),
      .load_i   (load),
      .shift_i  (shift),
      .prev_i   (prev),
      .view_o   (views[g]),
      .pipe_o   (pipes[g])
    );
  end
  assign cur = pipes[0];

  logic cur_held;
  assign cur_held = (cur.status == sva_pkg::ST_PLAY) || (cur.status == sva_pkg::ST_SUS);

  // Scan decision for the slot at pos_q.
  logic emit_hit;
  sva_pkg::action_e emit_act;
  sva_pkg::status_e emit_st;
  always_comb begin
    emit_hit = 1'b0;
    emit_act = sva_pkg::ACT_RELEASE;
    emit_st = sva_pkg::ST_REL;
    case (item_q.mode)
      sva_pkg::MODE_NOTE_ON: emit_hit = (pass_q == P_MONO) && cur_held;
      sva_pkg::MODE_PEDAL: emit_hit = !pedal_q && cur.status == sva_pkg::ST_SUS;
      sva_pkg::MODE_REL_ALL: emit_hit = cur_held;
      sva_pkg::MODE_TICK: begin
        emit_hit = kill_pend_q && cur.status != sva_pkg::ST_OFF;
        emit_act = sva_pkg::ACT_KILL;
        emit_st = sva_pkg::ST_OFF;
      end
      default: ;
    endcase
  end

  logic [5:0] lim;
  assign lim = (limit_q == '0) ? DefLimit : limit_q;
  logic key_ok;
  assign key_ok = (item_q.note >= min_key_q) && (item_q.note <= max_key_q);

  logic out_free;
  assign out_free = !obuf_v_q || out_ready_i;
  logic can_emit;
  assign can_emit = !pend_v_q || out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = obuf_v_q;
  assign out_data_o = obuf_q;

  sva_pkg::out_t new_res;
  logic push;           // new result into pending
  logic flush_last;     // pending goes out as last
  logic keep;           // result still within the per-item limit

  assign keep = (nres_q < ResW'(sva_pkg::MaxRes));

  always_comb begin
    state_d = state_q;
    pass_d = pass_q;
    ctl = '{cmd: sva_pkg::CMD_NONE, status: sva_pkg::ST_OFF, key: item_q.note};
    ctl_idx = sel_q;
    shift = 1'b0;
    push = 1'b0;
    flush_last = 1'b0;
    new_res = '{action: 2'(emit_act), slot: 4'(pos_q), slot_note: cur.key, last: 1'b0};
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_LOAD;
          pass_d = P_MAIN;
        end
      end
      S_LOAD: begin
        state_d = S_SCAN;
      end
      S_SCAN: begin
        shift = 1'b1;
        if (emit_hit) begin
          if (can_emit) begin
            push = 1'b1;
            ctl = '{cmd: (emit_act == sva_pkg::ACT_KILL) ? sva_pkg::CMD_KILL
                         : sva_pkg::CMD_SET, status: emit_st, key: item_q.note};
            ctl_idx = pos_q;
          end else begin
            shift = 1'b0;
          end
        end
        if (shift && pos_q == LastIdx) state_d = S_NEXT;
      end
      S_NEXT: begin
        shift = 1'b0;
        state_d = S_LOAD;
        case (item_q.mode)
          sva_pkg::MODE_NOTE_ON: begin
            case (pass_q)
              P_MAIN: begin
                if (!key_ok) state_d = S_FLUSH;
                else if (!poly_q) pass_d = P_MONO;
                else pass_d = P_START;
                if (poly_q && key_ok) state_d = S_NEXT;
              end
              P_MONO: begin
                pass_d = P_START;
                state_d = S_NEXT;
              end
              P_START: begin
                if (found_q && non_en_q && can_emit) begin
                  push = 1'b1;
                  new_res = '{action: 2'(sva_pkg::ACT_START), slot: 4'(free_q),
                              slot_note: item_q.note, last: 1'b0};
                  ctl = '{cmd: sva_pkg::CMD_START, status: sva_pkg::ST_PLAY,
                          key: item_q.note};
                  ctl_idx = free_q;
                end
                if (found_q && non_en_q && !can_emit) state_d = S_NEXT;
                else if (poly_q) pass_d = P_LIMIT;
                else state_d = S_FLUSH;
              end
              P_LIMIT: begin
                if (int'(held_q) > int'(lim) && old_ok_q) begin
                  state_d = S_NEXT;
                  pass_d = P_LREL;
                end else begin
                  state_d = S_FLUSH;
                end
              end
              P_LREL: begin
                if (can_emit) begin
                  push = 1'b1;
                  new_res = '{action: 2'(sva_pkg::ACT_RELEASE), slot: 4'(old_q),
                              slot_note: views[old_q].key, last: 1'b0};
                  ctl = '{cmd: sva_pkg::CMD_SET, status: sva_pkg::ST_REL,
                          key: item_q.note};
                  ctl_idx = old_q;
                  state_d = S_FLUSH;
                end else begin
                  state_d = S_NEXT;
                end
              end
              default: state_d = S_FLUSH;
            endcase
          end
          sva_pkg::MODE_NOTE_OFF: begin
            state_d = S_FLUSH;
            if (pedal_q) begin
              ctl = '{cmd: sva_pkg::CMD_SUS, status: sva_pkg::ST_SUS, key: item_q.note};
            end else if (found_q) begin
              if (can_emit) begin
                push = 1'b1;
                new_res = '{action: 2'(sva_pkg::ACT_RELEASE), slot: 4'(free_q),
                            slot_note: item_q.note, last: 1'b0};
                ctl = '{cmd: sva_pkg::CMD_SET, status: sva_pkg::ST_REL,
                        key: item_q.note};
                ctl_idx = free_q;
              end else begin
                state_d = S_NEXT;
              end
            end
          end
          sva_pkg::MODE_FINISHED: begin
            state_d = S_FLUSH;
            if (VOICES > 16 || int'(item_q.voice) < VOICES) begin
              if (views[IdxW'(item_q.voice)].status != sva_pkg::ST_OFF) begin
                if (can_emit) begin
                  push = 1'b1;
                  new_res = '{action: 2'(sva_pkg::ACT_KILL), slot: item_q.voice,
                              slot_note: views[IdxW'(item_q.voice)].key, last: 1'b0};
                  ctl = '{cmd: sva_pkg::CMD_KILL, status: sva_pkg::ST_OFF,
                          key: item_q.note};
                  ctl_idx = IdxW'(item_q.voice);
                end else begin
                  state_d = S_NEXT;
                end
              end
            end
          end
          default: state_d = S_FLUSH;
        endcase
      end
      S_FLUSH: begin
        shift = 1'b0;
        if (!pend_v_q) state_d = S_DONE;
        else if (out_free) begin
          flush_last = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        shift = 1'b0;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Ticks age all active cells in the load state of the item's main pass.
  always_comb begin
    ctl_f = ctl;
    if (state_q == S_LOAD && pass_q == P_MAIN && item_q.mode == sva_pkg::MODE_TICK)
      ctl_f = '{cmd: sva_pkg::CMD_AGE, status: sva_pkg::ST_OFF, key: item_q.note};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass_q <= P_MAIN;
      min_key_q <= '0;
      max_key_q <= 7'd127;
      poly_q <= 1'b1;
      non_en_q <= 1'b1;
      limit_q <= 6'd15;
      pedal_q <= 1'b0;
      kill_pend_q <= 1'b0;
      obuf_v_q <= 1'b0;
      pend_v_q <= 1'b0;
      nres_q <= '0;
    end else begin
      state_q <= state_d;
      pass_q <= pass_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          sva_pkg::REG_MIN_KEY:    min_key_q <= cfg_data_i;
          sva_pkg::REG_MAX_KEY:    max_key_q <= cfg_data_i;
          sva_pkg::REG_POLY_MODE:  poly_q <= cfg_data_i[0];
          sva_pkg::REG_NOTE_ON_EN: non_en_q <= cfg_data_i[0];
          sva_pkg::REG_KEY_LIMIT:  limit_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (state_q == S_IDLE && in_valid_i) begin
        nres_q <= '0;
        if (in_data_i.mode == sva_pkg::MODE_PEDAL)
          pedal_q <= (in_data_i.pedal_value >= 7'd64);
        if (in_data_i.mode == sva_pkg::MODE_KILL_ALL) kill_pend_q <= 1'b1;
      end
      if (state_q == S_DONE && item_q.mode == sva_pkg::MODE_TICK) kill_pend_q <= 1'b0;
      // pending -> output buffer
      if ((push && pend_v_q && keep) || flush_last) obuf_v_q <= 1'b1;
      else if (out_ready_i) obuf_v_q <= 1'b0;
      if (push) begin
        if (keep) begin
          pend_v_q <= 1'b1;
          nres_q <= nres_q + 1'b1;
        end
      end else if (flush_last) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) item_q <= in_data_i;
    if (push && pend_v_q && keep) obuf_q <= pend_q;
    else if (flush_last) obuf_q <= '{action: pend_q.action, slot: pend_q.slot,
                                     slot_note: pend_q.slot_note, last: 1'b1};
    if (push && keep) pend_q <= new_res;
  end

  // Scan bookkeeping.
  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD) begin
      pos_q <= '0;
      sel_q <= '0;
      if (pass_q == P_MAIN) found_q <= 1'b0;
      if (pass_q == P_LIMIT) begin
        held_q <= '0;
        maxage_q <= '0;
        old_ok_q <= 1'b0;
      end
    end else if (state_q == S_SCAN && shift) begin
      pos_q <= pos_q + 1'b1;
      if (pass_q == P_MAIN && item_q.mode == sva_pkg::MODE_NOTE_ON && !found_q
          && cur.status == sva_pkg::ST_OFF) begin
        found_q <= 1'b1;
        free_q <= pos_q;
      end
      // note-off keeps the highest matching playing slot
      if (item_q.mode == sva_pkg::MODE_NOTE_OFF && cur.status == sva_pkg::ST_PLAY
          && cur.key == item_q.note) begin
        found_q <= 1'b1;
        free_q <= pos_q;
      end
      if (pass_q == P_LIMIT && cur_held) begin
        held_q <= held_q + 1'b1;
        if (cur.age > maxage_q) begin
          maxage_q <= cur.age;
          old_q <= pos_q;
          old_ok_q <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the voice allocator: directed table plus random phases.
`timescale 1ns / 100ps

module testbench;
  import sva_pkg::*;

  localparam int Voices = 16;
  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 120;
  localparam logic [2:0] ModeUnused = 3'd7;

  // How a directed row is checked.
  typedef enum int {CHK_MODEL, CHK_ONE, CHK_NONE} chk_e;

  typedef struct {
    in_t  beat;
    chk_e chk;
    out_t res;
  } row_t;

  typedef struct {
    logic [6:0] min_key;
    logic [6:0] max_key;
    logic       poly;
    logic       on_en;
    logic [5:0] lim;
  } setting_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [6:0] cfg_data_i = '0;

  synth_voice_allocator_top #(.VOICES(Voices)) i_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Allocator mirror
  status_e     slot_st [Voices];
  logic [6:0]  slot_key [Voices];
  logic [23:0] slot_age [Voices];
  logic        pedal_dn, kill_pend;
  setting_t    cur;
  out_t        pending_q[$];
  out_t        new_res[$];

  int  errors = 0;
  int  cycles = 0;
  int  send_idle = 18;
  int  recv_idle = 69;

  function automatic void emit_action(action_e a, int s);
    out_t o;
    o.action = a;
    o.slot = s[3:0];
    o.slot_note = slot_key[s];
    o.last = 1'b0;
    new_res.push_back(o);
  endfunction

  function automatic void release_voice(int s);
    slot_st[s] = ST_REL;
    emit_action(ACT_RELEASE, s);
  endfunction

  function automatic void kill_voice(int s);
    emit_action(ACT_KILL, s);
    slot_st[s] = ST_OFF;
    slot_age[s] = '0;
  endfunction

  function automatic bit is_held(int s);
    return slot_st[s] == ST_PLAY || slot_st[s] == ST_SUS;
  endfunction

  function automatic void allocate_note(logic [6:0] n);
    int pos = -1;
    int cnt = 0;
    int oldest = -1;
    int lim;
    logic [23:0] maxage = '0;
    if (n < cur.min_key || n > cur.max_key) return;
    for (int i = 0; i < Voices; i++)
      if (pos < 0 && slot_st[i] == ST_OFF) pos = i;
    if (!cur.poly)
      for (int i = 0; i < Voices; i++)
        if (is_held(i)) release_voice(i);
    if (pos >= 0 && cur.on_en) begin
      slot_st[pos] = ST_PLAY;
      slot_key[pos] = n;
      emit_action(ACT_START, pos);
    end
    if (!cur.poly) return;
    lim = (cur.lim == 0) ? Voices - 5 : int'(cur.lim);
    for (int i = 0; i < Voices; i++)
      if (is_held(i)) cnt++;
    if (cnt <= lim) return;
    for (int i = 0; i < Voices; i++)
      if (is_held(i) && slot_age[i] > maxage) begin
        maxage = slot_age[i];
        oldest = i;
      end
    if (oldest >= 0) release_voice(oldest);
  endfunction

  // Updates the mirror for one beat and leaves its results in new_res.
  function automatic void allocate_beat(in_t b);
    new_res.delete();
    case (b.mode)
      MODE_NOTE_ON: allocate_note(b.note);
      MODE_NOTE_OFF: begin
        for (int i = Voices - 1; i >= 0; i--)
          if (slot_st[i] == ST_PLAY && slot_key[i] == b.note) begin
            if (!pedal_dn) begin
              release_voice(i);
              break;
            end
            slot_st[i] = ST_SUS;
          end
      end
      MODE_PEDAL: begin
        pedal_dn = b.pedal_value >= 64;
        if (!pedal_dn)
          for (int i = 0; i < Voices; i++)
            if (slot_st[i] == ST_SUS) release_voice(i);
      end
      MODE_REL_ALL: begin
        for (int i = 0; i < Voices; i++)
          if (is_held(i)) release_voice(i);
      end
      MODE_KILL_ALL: kill_pend = 1'b1;
      MODE_TICK: begin
        for (int i = 0; i < Voices; i++)
          if (slot_st[i] != ST_OFF && slot_age[i] != AgeMax) slot_age[i]++;
        if (kill_pend) begin
          for (int i = 0; i < Voices; i++)
            if (slot_st[i] != ST_OFF) kill_voice(i);
          kill_pend = 1'b0;
        end
      end
      MODE_FINISHED: begin
        if (slot_st[b.voice] != ST_OFF) kill_voice(int'(b.voice));
      end
      default: ;
    endcase
    if (new_res.size() > 0) new_res[new_res.size()-1].last = 1'b1;
  endfunction

  task automatic send_beat(in_t b, chk_e chk, out_t res);
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    allocate_beat(b);
    case (chk)
      CHK_ONE: pending_q.push_back(res);
      CHK_NONE: ;
      default: foreach (new_res[i]) pending_q.push_back(new_res[i]);
    endcase
  endtask

  task automatic write_reg(reg_e idx, logic [6:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MIN_KEY: cur.min_key = val;
      REG_MAX_KEY: cur.max_key = val;
      REG_POLY_MODE: cur.poly = val[0];
      REG_NOTE_ON_EN: cur.on_en = val[0];
      default: cur.lim = val[5:0];
    endcase
  endtask

  task automatic apply_setting(setting_t s);
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    write_reg(REG_MIN_KEY, s.min_key);
    write_reg(REG_MAX_KEY, s.max_key);
    write_reg(REG_POLY_MODE, {6'd0, s.poly});
    write_reg(REG_NOTE_ON_EN, {6'd0, s.on_en});
    write_reg(REG_KEY_LIMIT, {1'b0, s.lim});
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [6:0] pick_note();
    int n;
    if ($urandom_range(9) < 7) begin
      n = int'(cur.min_key) + $urandom_range(7);
      if (n > 127) n = 127;
      return n[6:0];
    end
    return 7'($urandom_range(127));
  endfunction

  function automatic in_t random_beat();
    in_t b;
    int  r = $urandom_range(99);
    b.note = 7'($urandom_range(127));
    b.pedal_value = 7'($urandom_range(127));
    b.voice = 4'($urandom_range(15));
    if (r < 40) begin
      b.mode = MODE_NOTE_ON;
      b.note = pick_note();
    end else if (r < 60) begin
      b.mode = MODE_NOTE_OFF;
      b.note = pick_note();
    end else if (r < 68) b.mode = MODE_PEDAL;
    else if (r < 83) b.mode = MODE_TICK;
    else if (r < 91) b.mode = MODE_FINISHED;
    else if (r < 94) b.mode = MODE_REL_ALL;
    else if (r < 97) b.mode = MODE_KILL_ALL;
    else b.mode = ModeUnused;
    return b;
  endfunction

  function automatic row_t mk(logic [2:0] m, int n, int p, int v, chk_e c,
                              action_e a = ACT_START, int s = 0, int sn = 0);
    row_t r;
    r.beat.mode = m;
    r.beat.note = n[6:0];
    r.beat.pedal_value = p[6:0];
    r.beat.voice = v[3:0];
    r.chk = c;
    r.res.action = a;
    r.res.slot = s[3:0];
    r.res.slot_note = sn[6:0];
    r.res.last = 1'b1;
    return r;
  endfunction

  // Result checker and receiver stalls
  always @(posedge clk_i) begin
    out_t e;
    cycles <= cycles + 1;
    if (out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data_o);
        errors <= errors + 1;
      end else begin
        e = pending_q.pop_front();
        if (out_data_o.action !== e.action || out_data_o.slot !== e.slot ||
            out_data_o.slot_note !== e.slot_note || out_data_o.last !== e.last) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, out_data_o);
          errors <= errors + 1;
        end
      end
    end
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i)
    if (cycles >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end

  row_t     dir_rows[$];
  setting_t phases[8];

  initial begin
    for (int i = 0; i < Voices; i++) begin
      slot_st[i] = ST_OFF;
      slot_key[i] = '0;
      slot_age[i] = '0;
    end
    pedal_dn = 1'b0;
    kill_pend = 1'b0;
    cur = '{7'd0, 7'd127, 1'b1, 1'b1, 6'd15};

    dir_rows.push_back(mk(MODE_NOTE_ON, 60, 0, 0, CHK_ONE, ACT_START, 0, 60));
    dir_rows.push_back(mk(MODE_NOTE_ON, 0, 0, 0, CHK_ONE, ACT_START, 1, 0));
    dir_rows.push_back(mk(MODE_NOTE_ON, 127, 0, 0, CHK_ONE, ACT_START, 2, 127));
    dir_rows.push_back(mk(MODE_TICK, 0, 0, 0, CHK_NONE));
    dir_rows.push_back(mk(MODE_NOTE_OFF, 60, 0, 0, CHK_ONE, ACT_RELEASE, 0, 60));
    dir_rows.push_back(mk(MODE_PEDAL, 0, 127, 0, CHK_NONE));
    // released slot 0 is not free, so the next start goes to slot 3
    dir_rows.push_back(mk(MODE_NOTE_ON, 5, 0, 0, CHK_ONE, ACT_START, 3, 5));
    dir_rows.push_back(mk(MODE_NOTE_OFF, 5, 0, 0, CHK_NONE));
    dir_rows.push_back(mk(MODE_PEDAL, 0, 63, 0, CHK_ONE, ACT_RELEASE, 3, 5));
    dir_rows.push_back(mk(MODE_PEDAL, 127, 64, 15, CHK_NONE));
    dir_rows.push_back(mk(MODE_NOTE_OFF, 127, 0, 0, CHK_NONE));
    dir_rows.push_back(mk(MODE_REL_ALL, 0, 0, 0, CHK_MODEL));
    dir_rows.push_back(mk(MODE_KILL_ALL, 0, 0, 0, CHK_NONE));
    dir_rows.push_back(mk(MODE_TICK, 0, 0, 0, CHK_MODEL));
    dir_rows.push_back(mk(MODE_FINISHED, 127, 127, 15, CHK_NONE));
    dir_rows.push_back(mk(ModeUnused, 127, 127, 15, CHK_NONE));
    dir_rows.push_back(mk(MODE_NOTE_ON, 64, 0, 0, CHK_ONE, ACT_START, 0, 64));
    dir_rows.push_back(mk(MODE_FINISHED, 0, 0, 0, CHK_ONE, ACT_KILL, 0, 64));
    dir_rows.push_back(mk(MODE_PEDAL, 0, 0, 0, CHK_NONE));

    phases[0] = '{7'd0, 7'd127, 1'b1, 1'b1, 6'd0};
    phases[1] = '{7'd20, 7'd100, 1'b1, 1'b1, 6'd2};
    phases[2] = '{7'd0, 7'd127, 1'b0, 1'b1, 6'd1};
    phases[3] = '{7'd127, 7'd127, 1'b1, 1'b1, 6'd63};
    phases[4] = '{7'd0, 7'd0, 1'b1, 1'b0, 6'd5};
    phases[5] = '{7'd30, 7'd90, 1'b1, 1'b1, 6'd4};
    phases[6] = '{7'd0, 7'd127, 1'b1, 1'b1, 6'd15};
    phases[7] = '{7'd10, 7'd40, 1'b0, 1'b1, 6'd42};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].chk, dir_rows[i].res);

    foreach (phases[p]) begin
      if (p == 3) begin
        send_idle = 69;
        recv_idle = 18;
      end else if (p == 6) begin
        send_idle = 0;
        recv_idle = 0;
      end
      apply_setting(phases[p]);
      repeat (38) send_beat(random_beat(), CHK_MODEL, '0);
    end

    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
design/sva_pkg.sv
design/sva_cell.sv
design/synth_voice_allocator_top.sv
tb/testbench.sv
